// ----- hw/rtl/cawb_pkg.sv -----
// shared constants, types and field offsets for the cluster age/evict/write-back core
package cawb_pkg;

    localparam int SECTORS_PER_CLUSTER = 16;
    localparam int USE_COUNT_BITS      = 4;

    localparam int SECTOR_W    = 48;
    localparam int MASK_W      = 16;
    localparam int USE_W       = 64;
    localparam int BUDGET_W    = 32;
    localparam int RUN_LEN_W   = 5;

    localparam int IDX_W       = $clog2(SECTORS_PER_CLUSTER);
    localparam int LEN_W       = $clog2(SECTORS_PER_CLUSTER + 1);
    localparam int USE_POS_W   = $clog2(USE_W);

    // input word layout, lowest bit first
    localparam int IN_NEW_SCAN = 0;
    localparam int IN_DO_FREE  = 1;
    localparam int IN_DO_WRITE = 2;
    localparam int IN_SECTOR   = 3;
    localparam int IN_PRESENT  = IN_SECTOR + SECTOR_W;
    localparam int IN_LOADED   = IN_PRESENT + MASK_W;
    localparam int IN_DIRTY    = IN_LOADED + MASK_W;
    localparam int IN_USE      = IN_DIRTY + MASK_W;
    localparam int IN_BITS     = IN_USE + USE_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output word layout, lowest bit first
    localparam int OUT_BITS    = SECTOR_W + RUN_LEN_W + 2 * MASK_W + USE_W + 2 * BUDGET_W;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic REG_FREE_BUDGET  = 1'b0;
    localparam logic REG_WRITE_BUDGET = 1'b1;

    // result kinds
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVICT  = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic load_item;
        logic evict_step;
        logic write_step;
        logic emit_final;
        logic clear_idx;
    } cmd_t;

    typedef struct packed {
        logic in_do_free;
        logic in_do_write;
        logic do_write;
        logic last_idx;
        logic free_zero;
        logic write_zero;
        logic run_close;
        logic slot_free;
    } status_t;

endpackage

// ----- hw/rtl/cawb_ctrl.sv -----
// sequencing state machine: load, eviction walk, write-back walk, finish word
module cawb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cawb_pkg::status_t  status,
    output cawb_pkg::cmd_t     cmd
);

    cawb_pkg::state_t state_reg;
    cawb_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            cawb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    if (status.in_do_free)
                        state_next = cawb_pkg::ST_EVICT;
                    else if (status.in_do_write)
                        state_next = cawb_pkg::ST_WRITE;
                    else
                        state_next = cawb_pkg::ST_FINISH;
                end
            end
            cawb_pkg::ST_EVICT:
            begin
                cmd.evict_step = !status.free_zero;
                if (status.free_zero || status.last_idx)
                begin
                    cmd.clear_idx = 1'b1;
                    state_next = status.do_write ? cawb_pkg::ST_WRITE : cawb_pkg::ST_FINISH;
                end
            end
            cawb_pkg::ST_WRITE:
            begin
                if (status.write_zero)
                    state_next = cawb_pkg::ST_FINISH;
                else if (!status.run_close || status.slot_free)
                begin
                    // a closing run needs the output slot, otherwise hold
                    cmd.write_step = 1'b1;
                    if (status.last_idx)
                        state_next = cawb_pkg::ST_FINISH;
                end
            end
            cawb_pkg::ST_FINISH:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next = cawb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cawb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cawb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/cawb_datapath.sv -----
// cluster registers, budgets, per-sector step logic and the output word register
module cawb_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cawb_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cawb_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [cawb_pkg::BUDGET_W-1:0]     cfg_wr_data,
    input  cawb_pkg::cmd_t                    cmd,
    output cawb_pkg::status_t                 status
);

    logic [cawb_pkg::BUDGET_W-1:0]  cfg_free_reg;
    logic [cawb_pkg::BUDGET_W-1:0]  cfg_write_reg;
    logic [cawb_pkg::BUDGET_W-1:0]  free_rem_reg,  free_rem_next;
    logic [cawb_pkg::BUDGET_W-1:0]  write_rem_reg, write_rem_next;

    logic                           do_write_reg,  do_write_next;
    logic [cawb_pkg::IDX_W-1:0]     idx_reg,       idx_next;
    logic [cawb_pkg::LEN_W-1:0]     run_len_reg,   run_len_next;
    logic [cawb_pkg::IDX_W-1:0]     run_first_reg, run_first_next;
    logic [cawb_pkg::SECTOR_W-1:0]  base_reg,      base_next;
    logic [cawb_pkg::MASK_W-1:0]    present_reg,   present_next;
    logic [cawb_pkg::MASK_W-1:0]    loaded_reg,    loaded_next;
    logic [cawb_pkg::MASK_W-1:0]    dirty_reg,     dirty_next;
    logic [cawb_pkg::USE_W-1:0]     use_reg,       use_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_kind_reg,  out_kind_next;
    logic [cawb_pkg::SECTOR_W-1:0]  out_sector_reg, out_sector_next;
    logic [cawb_pkg::RUN_LEN_W-1:0] out_len_reg,   out_len_next;
    logic [cawb_pkg::MASK_W-1:0]    out_present_reg, out_present_next;
    logic [cawb_pkg::MASK_W-1:0]    out_dirty_reg, out_dirty_next;
    logic [cawb_pkg::USE_W-1:0]     out_use_reg,   out_use_next;
    logic [cawb_pkg::BUDGET_W-1:0]  out_free_reg,  out_free_next;
    logic [cawb_pkg::BUDGET_W-1:0]  out_write_reg, out_write_next;

    logic [cawb_pkg::USE_POS_W-1:0]      cnt_pos;
    logic [cawb_pkg::USE_COUNT_BITS-1:0] cnt;
    logic                                last_idx;
    logic                                slot_free;
    logic                                join_run;
    logic [cawb_pkg::BUDGET_W-1:0]       write_dec;
    logic [cawb_pkg::LEN_W-1:0]          len_inc;
    logic [cawb_pkg::IDX_W-1:0]          first_sel;
    logic                                run_close;

    assign cnt_pos   = cawb_pkg::USE_POS_W'(idx_reg)
                     * cawb_pkg::USE_POS_W'(cawb_pkg::USE_COUNT_BITS);
    assign cnt       = use_reg[cnt_pos +: cawb_pkg::USE_COUNT_BITS];
    assign last_idx  = (idx_reg == cawb_pkg::IDX_W'(cawb_pkg::SECTORS_PER_CLUSTER - 1));
    assign slot_free = !out_valid_reg || m_tready;

    // write-back step on the current sector
    assign join_run  = dirty_reg[idx_reg];
    assign write_dec = write_rem_reg - cawb_pkg::BUDGET_W'(join_run);
    assign len_inc   = run_len_reg + cawb_pkg::LEN_W'(join_run);
    assign first_sel = (run_len_reg == '0) ? idx_reg : run_first_reg;
    assign run_close = join_run ? (last_idx || (write_dec == '0)) : (run_len_reg != '0);

    always_comb
    begin
        status.in_do_free  = s_tdata[cawb_pkg::IN_DO_FREE];
        status.in_do_write = s_tdata[cawb_pkg::IN_DO_WRITE];
        status.do_write    = do_write_reg;
        status.last_idx    = last_idx;
        status.free_zero   = (free_rem_reg == '0);
        status.write_zero  = (write_rem_reg == '0);
        status.run_close   = run_close;
        status.slot_free   = slot_free;
    end

    always_comb
    begin
        free_rem_next    = free_rem_reg;
        write_rem_next   = write_rem_reg;
        do_write_next    = do_write_reg;
        idx_next         = idx_reg;
        run_len_next     = run_len_reg;
        run_first_next   = run_first_reg;
        base_next        = base_reg;
        present_next     = present_reg;
        loaded_next      = loaded_reg;
        dirty_next       = dirty_reg;
        use_next         = use_reg;

        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_sector_next  = out_sector_reg;
        out_len_next     = out_len_reg;
        out_present_next = out_present_reg;
        out_dirty_next   = out_dirty_reg;
        out_use_next     = out_use_reg;
        out_free_next    = out_free_reg;
        out_write_next   = out_write_reg;

        if (cmd.load_item)
        begin
            do_write_next = s_tdata[cawb_pkg::IN_DO_WRITE];
            base_next     = s_tdata[cawb_pkg::IN_SECTOR +: cawb_pkg::SECTOR_W];
            present_next  = s_tdata[cawb_pkg::IN_PRESENT +: cawb_pkg::MASK_W];
            loaded_next   = s_tdata[cawb_pkg::IN_LOADED +: cawb_pkg::MASK_W];
            dirty_next    = s_tdata[cawb_pkg::IN_DIRTY +: cawb_pkg::MASK_W];
            use_next      = s_tdata[cawb_pkg::IN_USE +: cawb_pkg::USE_W];
            idx_next      = '0;
            run_len_next  = '0;
            if (s_tdata[cawb_pkg::IN_NEW_SCAN])
            begin
                free_rem_next  = cfg_free_reg;
                write_rem_next = cfg_write_reg;
            end
        end

        if (cmd.evict_step)
        begin
            idx_next = idx_reg + 1'b1;
            if (present_reg[idx_reg] && loaded_reg[idx_reg])
            begin
                if (cnt != '0)
                    use_next[cnt_pos +: cawb_pkg::USE_COUNT_BITS] = cnt - 1'b1;
                else if (!dirty_reg[idx_reg])
                begin
                    present_next[idx_reg] = 1'b0;
                    free_rem_next         = free_rem_reg - 1'b1;
                end
            end
        end

        if (cmd.write_step)
        begin
            idx_next       = idx_reg + 1'b1;
            write_rem_next = write_dec;
            // written sectors leave the dirty mask as they join a run
            if (join_run)
                dirty_next[idx_reg] = 1'b0;
            if (run_close)
            begin
                run_len_next     = '0;
                out_valid_next   = 1'b1;
                out_kind_next    = cawb_pkg::KIND_RUN;
                out_sector_next  = base_reg + cawb_pkg::SECTOR_W'(first_sel);
                out_len_next     = cawb_pkg::RUN_LEN_W'(len_inc);
                out_present_next = '0;
                out_dirty_next   = '0;
                out_use_next     = '0;
                out_free_next    = '0;
                out_write_next   = '0;
            end
            else
            begin
                run_len_next   = len_inc;
                run_first_next = first_sel;
            end
        end

        if (cmd.clear_idx)
            idx_next = '0;

        if (cmd.emit_final)
        begin
            out_valid_next   = 1'b1;
            out_kind_next    = cawb_pkg::KIND_FINISH;
            out_sector_next  = '0;
            out_len_next     = '0;
            out_present_next = present_reg;
            out_dirty_next   = dirty_reg;
            out_use_next     = use_reg;
            out_free_next    = free_rem_reg;
            out_write_next   = write_rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_free_reg  <= '0;
            cfg_write_reg <= '0;
            free_rem_reg  <= '0;
            write_rem_reg <= '0;
            do_write_reg  <= 1'b0;
            idx_reg       <= '0;
            run_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    cawb_pkg::REG_FREE_BUDGET:  cfg_free_reg  <= cfg_wr_data;
                    cawb_pkg::REG_WRITE_BUDGET: cfg_write_reg <= cfg_wr_data;
                endcase
            end
            free_rem_reg  <= free_rem_next;
            write_rem_reg <= write_rem_next;
            do_write_reg  <= do_write_next;
            idx_reg       <= idx_next;
            run_len_reg   <= run_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_first_reg   <= run_first_next;
        base_reg        <= base_next;
        present_reg     <= present_next;
        loaded_reg      <= loaded_next;
        dirty_reg       <= dirty_next;
        use_reg         <= use_next;
        out_kind_reg    <= out_kind_next;
        out_sector_reg  <= out_sector_next;
        out_len_reg     <= out_len_next;
        out_present_reg <= out_present_next;
        out_dirty_reg   <= out_dirty_next;
        out_use_reg     <= out_use_next;
        out_free_reg    <= out_free_next;
        out_write_reg   <= out_write_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = (out_kind_reg == cawb_pkg::KIND_FINISH);
    assign m_tdata  = cawb_pkg::M_TDATA_W'({out_write_reg, out_free_reg, out_use_reg,
                                            out_dirty_reg, out_present_reg, out_len_reg,
                                            out_sector_reg});

endmodule

// ----- hw/rtl/cluster_age_evict_writeback_core.sv -----
// top level of the cluster age/evict/write-back core
// One cluster word is taken at a time. It is loaded, then stepped sector by sector
// through the eviction walk (up to 16, ending early once the free budget is used up)
// and the write-back walk (up to 16, ending early once the write budget is used up),
// either of which the word may switch off, and then the finish word is sent. The
// single-sector step unit looks at one sector per cycle in either walk, save while a
// write-back walk stalls on the output register. Each dirty run leaves as its own
// word through a one-deep output register; a run that closes while that register is
// still held stalls the walk until it drains. Budgets carry over from cluster to
// cluster and are reloaded from the two configuration registers on a new scan.
module cluster_age_evict_writeback_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // new_scan, do_free, do_write, cluster_sector, present_bits, loaded_bits,
    // dirty_bits, use_counts
    input  logic [cawb_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // run_sector, run_length, present_after, dirty_after, use_after, free_left, write_left
    output logic [cawb_pkg::M_TDATA_W-1:0]    m_tdata,
    // kind
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [cawb_pkg::BUDGET_W-1:0]     cfg_wr_data
);

    cawb_pkg::cmd_t    cmd;
    cawb_pkg::status_t status;

    cawb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cawb_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- hw/rtl/cawb_checker.sv -----
// port-level checks for the cluster age/evict/write-back core and their binding
module cawb_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [cawb_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tuser,
    input  logic                              m_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready
);

    logic [cawb_pkg::RUN_LEN_W-1:0] run_len;

    assign run_len = m_tdata[cawb_pkg::SECTOR_W +: cawb_pkg::RUN_LEN_W];

    // a held word keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("held output word changed");

    // only the finish word closes a cluster
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == cawb_pkg::KIND_FINISH)))
    else $error("tlast does not match the finish kind");

    // run words carry a length within the cluster
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == cawb_pkg::KIND_RUN) |->
            (run_len != '0) &&
            (run_len <= cawb_pkg::RUN_LEN_W'(cawb_pkg::SECTORS_PER_CLUSTER)))
    else $error("run length out of range");

    // one cluster at a time: no new word straight after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a cluster is in progress");

endmodule

bind cluster_age_evict_writeback_core cawb_checker u_cawb_checker (.*);
